// ----- design/mrfc_pkg.sv -----
// shared types, function codes and length lookup for the modbus request frame checker
package mrfc_pkg;

  // result status codes
  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StCrc      = 2'd1,
    StIllegal  = 2'd2,
    StOverflow = 2'd3
  } status_e;

  // supported modbus function codes
  localparam logic [7:0] FcReadCoils        = 8'd1;
  localparam logic [7:0] FcReadHolding      = 8'd3;
  localparam logic [7:0] FcReadInput        = 8'd4;
  localparam logic [7:0] FcWriteCoil        = 8'd5;
  localparam logic [7:0] FcWriteReg         = 8'd6;
  localparam logic [7:0] FcReadExcStatus    = 8'd7;
  localparam logic [7:0] FcDiagnostics      = 8'd8;
  localparam logic [7:0] FcCommEventCounter = 8'd11;
  localparam logic [7:0] FcCommEventLog     = 8'd12;
  localparam logic [7:0] FcWriteCoils       = 8'd15;
  localparam logic [7:0] FcWriteRegs        = 8'd16;
  localparam logic [7:0] FcReportServerId   = 8'd17;
  localparam logic [7:0] FcMaskWriteReg     = 8'd22;

  // length lookup codes besides real lengths
  localparam logic [3:0] LenUnsupported = 4'd0;
  localparam logic [3:0] LenCounted     = 4'd1;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  function_code;
    logic        broadcast;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [8:0]  frame_length;
  } out_t;

  // expected frame length for a function code
  function automatic logic [3:0] length_for(input logic [7:0] fc);
    logic [3:0] len;
    case (fc) inside
      FcReadCoils, FcReadHolding, FcReadInput, FcWriteCoil, FcWriteReg,
      FcDiagnostics:                                      len = 4'd8;
      FcReadExcStatus, FcCommEventCounter, FcCommEventLog,
      FcReportServerId:                                   len = 4'd4;
      FcMaskWriteReg:                                     len = 4'd10;
      FcWriteCoils, FcWriteRegs:                          len = LenCounted;
      default:                                            len = LenUnsupported;
    endcase
    return len;
  endfunction

endpackage

// ----- design/mrfc_crc_byte.sv -----
// unrolled one-byte crc-16 update, reflected polynomial
module mrfc_crc_byte
  import mrfc_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ----- design/mrfc_frame_core.sv -----
// frame state registers and per-byte decision logic
module mrfc_frame_core
  import mrfc_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  in_t        item_i,
  input  logic [7:0] own_address_i,
  output logic       emit_o,
  output out_t       result_o
);

  localparam logic [9:0] MaxFrame = 10'(MAX_FRAME);

  logic [8:0]  byte_index_q, byte_index_d;
  logic [15:0] crc_q, crc_d;
  logic [9:0]  exp_len_q, exp_len_d;
  logic [7:0]  func_q, func_d;
  logic        bcast_q, bcast_d;
  logic        skip_q, skip_d;
  logic [15:0] word_one_q, word_one_d;
  logic [15:0] word_two_q, word_two_d;

  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [3:0]  len_code;
  logic        in_body;
  logic        emit;
  status_e     status;

  mrfc_crc_byte u_crc (
    .crc_i  (crc_base),
    .data_i (item_i.data_byte),
    .crc_o  (crc_next)
  );

  assign crc_base = item_i.frame_start ? CrcInit : crc_q;
  assign len_code = length_for(item_i.data_byte);

  always_comb begin
    // frame start clears the frame state first
    if (item_i.frame_start) begin
      byte_index_d = '0;
      crc_d        = CrcInit;
      exp_len_d    = '0;
      func_d       = '0;
      bcast_d      = 1'b0;
      skip_d       = 1'b0;
      word_one_d   = '0;
      word_two_d   = '0;
    end else begin
      byte_index_d = byte_index_q;
      crc_d        = crc_q;
      exp_len_d    = exp_len_q;
      func_d       = func_q;
      bcast_d      = bcast_q;
      skip_d       = skip_q;
      word_one_d   = word_one_q;
      word_two_d   = word_two_q;
    end
    emit    = 1'b0;
    status  = StOk;
    in_body = 1'b0;

    if (!skip_d) begin
      if ({1'b0, byte_index_d} >= MaxFrame) begin
        emit   = 1'b1;
        status = StOverflow;
      end else begin
        in_body = (exp_len_d == '0) || (({1'b0, byte_index_d} + 10'd2) < exp_len_d);
        crc_d   = crc_next;
        case (byte_index_d)
          9'd0: begin
            if (item_i.data_byte != own_address_i && item_i.data_byte != 8'd0) begin
              skip_d = 1'b1;
            end else begin
              bcast_d = (item_i.data_byte == 8'd0);
            end
          end
          9'd1: begin
            func_d = item_i.data_byte;
            if (len_code == LenUnsupported) begin
              emit   = 1'b1;
              status = StIllegal;
            end else if (len_code != LenCounted) begin
              exp_len_d = {6'd0, len_code};
            end
          end
          9'd2: if (in_body) word_one_d[15:8] = item_i.data_byte;
          9'd3: if (in_body) word_one_d[7:0]  = item_i.data_byte;
          9'd4: if (in_body) word_two_d[15:8] = item_i.data_byte;
          9'd5: if (in_body) word_two_d[7:0]  = item_i.data_byte;
          9'd6: begin
            if (func_d == FcWriteCoils || func_d == FcWriteRegs) begin
              exp_len_d = 10'd9 + {2'd0, item_i.data_byte};
            end
          end
          default: ;
        endcase
        byte_index_d = byte_index_d + 9'd1;
        if (!emit && !skip_d && exp_len_d != '0 && {1'b0, byte_index_d} == exp_len_d) begin
          emit   = 1'b1;
          status = (crc_d == 16'd0) ? StOk : StCrc;
        end
      end
      if (emit) begin
        skip_d = 1'b1;
      end
    end
  end

  always_comb begin
    result_o.status        = status;
    result_o.function_code = func_d;
    result_o.broadcast     = bcast_d;
    result_o.first_word    = word_one_d;
    result_o.second_word   = word_two_d;
    result_o.frame_length  = byte_index_d;
  end

  assign emit_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      crc_q        <= CrcInit;
      exp_len_q    <= '0;
      func_q       <= '0;
      bcast_q      <= 1'b0;
      skip_q       <= 1'b1;
      word_one_q   <= '0;
      word_two_q   <= '0;
    end else if (step_i) begin
      byte_index_q <= byte_index_d;
      crc_q        <= crc_d;
      exp_len_q    <= exp_len_d;
      func_q       <= func_d;
      bcast_q      <= bcast_d;
      skip_q       <= skip_d;
      word_one_q   <= word_one_d;
      word_two_q   <= word_two_d;
    end
  end

endmodule

// ----- design/modbus_rtu_request_frame_checker_top.sv -----
// top level of the modbus rtu request frame checker
//
//   channel   direction  handshake              payload
//   in        input      in_valid_i/in_ready_o   in_data_i (in_t: data byte, frame start)
//   out       output     out_valid_o/out_ready_i out_data_o (out_t: status, words, length)
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_data_i (own station address)
//
// one byte per cycle while the result register is not stalled; a taken byte waits in the input
// register and is processed out of it, and its result (if any) is registered in that same cycle
// reset leaves the checker waiting for a frame start, own address 1
// a stalled result only holds back the input register: one more byte is taken
// and waits while the result register is full
module modbus_rtu_request_frame_checker_top
  import mrfc_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic       in_valid_q, in_valid_d;
  in_t        in_q;
  logic       out_valid_q, out_valid_d;
  out_t       out_q;
  logic [7:0] own_address_q;

  logic       advance;
  logic       emit;
  out_t       result;

  // the held byte moves into the frame logic whenever the result slot is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  mrfc_frame_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .item_i        (in_q),
    .own_address_i (own_address_q),
    .emit_o        (emit),
    .result_o      (result)
  );

  // input register valid
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // result register valid, a new result only lands in a free or draining slot
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      own_address_q <= 8'd1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        own_address_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (emit) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- bench/testbench.sv -----
// self-checking testbench for the modbus rtu request frame checker
module testbench;
  import mrfc_pkg::*;

  localparam int MaxFrame = 256;

  // read discrete inputs: a real modbus code that this checker does not support
  localparam logic [7:0] FcReadDiscrete = 8'd2;

  // how the body bytes of a built request are filled
  localparam int FillRandom = 0;
  localparam int FillZero   = 1;
  localparam int FillOnes   = 2;

  // receiver back-pressure patterns
  typedef enum int {SinkOpen, SinkCoin, SinkSparse, SinkBeat} sink_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  out_t       out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;

  // one byte through the modbus crc-16 (reflected, lsb first)
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  // request length implied by the function byte, or the two marker codes
  function automatic logic [8:0] request_length(input logic [7:0] fc);
    case (fc)
      FcReadCoils, FcReadHolding, FcReadInput, FcWriteCoil, FcWriteReg,
      FcDiagnostics:                                          return 9'd8;
      FcReadExcStatus, FcCommEventCounter, FcCommEventLog,
      FcReportServerId:                                       return 9'd4;
      FcMaskWriteReg:                                         return 9'd10;
      FcWriteCoils, FcWriteRegs:                              return 9'(LenCounted);
      default:                                                return 9'(LenUnsupported);
    endcase
  endfunction

  // tracks the frame state of the checker and holds the verdicts still owed
  class frame_tracker;
    logic [7:0]  own_addr;
    logic [8:0]  byte_idx;
    logic [8:0]  frame_len;
    logic [15:0] crc;
    logic [7:0]  func;
    logic        bcast;
    logic        skipping;
    logic [15:0] word_one;
    logic [15:0] word_two;
    out_t        verdicts_due[$];
    int          errors;

    function new();
      own_addr = 8'd1;
      byte_idx = '0;
      frame_len = '0;
      crc = CrcInit;
      func = '0;
      bcast = 1'b0;
      skipping = 1'b1;
      word_one = '0;
      word_two = '0;
      errors = 0;
    endfunction

    function void conclude(status_e st);
      out_t v;
      v.status = st;
      v.function_code = func;
      v.broadcast = bcast;
      v.first_word = word_one;
      v.second_word = word_two;
      v.frame_length = byte_idx;
      verdicts_due.push_back(v);
      skipping = 1'b1;
    endfunction

    // returns 1 when the byte is part of a frame under check
    function bit note_byte(in_t item);
      logic [8:0] idx;
      logic [8:0] len;
      logic [7:0] b;
      bit         body;
      b = item.data_byte;
      if (item.frame_start) begin
        byte_idx = '0;
        frame_len = '0;
        crc = CrcInit;
        func = '0;
        bcast = 1'b0;
        skipping = 1'b0;
        word_one = '0;
        word_two = '0;
      end
      if (skipping) return 0;
      if (byte_idx >= MaxFrame) begin
        conclude(StOverflow);
        return 1;
      end
      crc = crc16_next(crc, b);
      idx = byte_idx;
      byte_idx = idx + 9'd1;
      // crc bytes never land in the header words
      body = (frame_len == 0) || (idx + 2 < frame_len);
      case (idx)
        9'd0: begin
          if (b != own_addr && b != 8'd0) begin
            skipping = 1'b1;
            return 1;
          end
          bcast = (b == 8'd0);
        end
        9'd1: begin
          len = request_length(b);
          func = b;
          if (len == LenUnsupported) begin
            conclude(StIllegal);
            return 1;
          end
          if (len != LenCounted) frame_len = len;
        end
        9'd2: if (body) word_one[15:8] = b;
        9'd3: if (body) word_one[7:0] = b;
        9'd4: if (body) word_two[15:8] = b;
        9'd5: if (body) word_two[7:0] = b;
        9'd6: if (func == FcWriteCoils || func == FcWriteRegs) frame_len = 9'd9 + {1'b0, b};
        default: ;
      endcase
      if (frame_len != 0 && byte_idx == frame_len) conclude(crc == 16'd0 ? StOk : StCrc);
      return 1;
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= 10) $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (verdicts_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result 0x%h arrived with nothing outstanding", got);
        return;
      end
      want = verdicts_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("function_code", want.function_code, got.function_code);
      compare_field("broadcast", want.broadcast, got.broadcast);
      compare_field("first_word", want.first_word, got.first_word);
      compare_field("second_word", want.second_word, got.second_word);
      compare_field("frame_length", want.frame_length, got.frame_length);
    endfunction

    function void flag_missing();
      if (verdicts_due.size() != 0) begin
        errors += verdicts_due.size();
        $display("%0d results never arrived", verdicts_due.size());
      end
    endfunction
  endclass

  frame_tracker sb = new();

  in_t tx_bytes[$];   // bytes of the frame being built, oldest first
  int  burst_left;    // bytes left in the current sender burst
  int  sent_bytes;    // input transactions sent so far

  modbus_rtu_request_frame_checker_top #(
    .MAX_FRAME(MaxFrame)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void add_byte(input logic [7:0] b, input bit s);
    in_t item;
    item.data_byte = b;
    item.frame_start = s;
    tx_bytes.push_back(item);
  endfunction

  // one request with its crc appended low byte first; counted codes carry
  // the byte count in the seventh byte
  function automatic void build_request(input logic [7:0] addr, input logic [7:0] fc,
                                        input int count, input bit crc_ok, input int fill);
    logic [15:0] c;
    logic [8:0]  len;
    int          body_n;
    int          first;
    logic [7:0]  b;
    first = tx_bytes.size();
    len = request_length(fc);
    add_byte(addr, 1'b1);
    add_byte(fc, 1'b0);
    if (len == LenCounted) body_n = 5 + count;
    else if (len == LenUnsupported) body_n = $urandom_range(0, 6);
    else body_n = int'(len) - 4;
    for (int i = 0; i < body_n; i++) begin
      if (len == LenCounted && i == 4) b = 8'(count);
      else if (fill == FillZero) b = 8'h00;
      else if (fill == FillOnes) b = 8'hFF;
      else b = 8'($urandom_range(0, 255));
      add_byte(b, 1'b0);
    end
    c = CrcInit;
    for (int i = first; i < tx_bytes.size(); i++) c = crc16_next(c, tx_bytes[i].data_byte);
    if (!crc_ok) c ^= 16'($urandom_range(1, 65535));
    add_byte(c[7:0], 1'b0);
    add_byte(c[15:8], 1'b0);
  endfunction

  function automatic logic [7:0] pick_supported();
    case ($urandom_range(0, 12))
      0:       return FcReadCoils;
      1:       return FcReadHolding;
      2:       return FcReadInput;
      3:       return FcWriteCoil;
      4:       return FcWriteReg;
      5:       return FcReadExcStatus;
      6:       return FcDiagnostics;
      7:       return FcCommEventCounter;
      8:       return FcCommEventLog;
      9:       return FcWriteCoils;
      10:      return FcWriteRegs;
      11:      return FcReportServerId;
      default: return FcMaskWriteReg;
    endcase
  endfunction

  // one random frame, mostly well formed; the rest truncated, noise or junk
  function automatic void random_frame(input bit overflow);
    int         kind;
    int         pick;
    int         count;
    int         fill;
    logic [7:0] addr;
    logic [7:0] fc;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (pick < 60) addr = sb.own_addr;
    else if (pick < 85) addr = 8'd0;
    else begin
      do addr = 8'($urandom_range(1, 255)); while (addr == sb.own_addr);
    end
    if ($urandom_range(0, 99) < 8) begin
      if ($urandom_range(0, 3) == 0) fc = FcReadDiscrete;
      else begin
        do fc = 8'($urandom_range(0, 255)); while (request_length(fc) != LenUnsupported);
      end
    end else begin
      fc = pick_supported();
    end
    // long counted frames: 247 fills the frame exactly, beyond that overflows
    count = ($urandom_range(0, 99) < 3) ? $urandom_range(240, 255) : $urandom_range(0, 12);
    pick = $urandom_range(0, 19);
    fill = (pick == 0) ? FillZero : (pick == 1) ? FillOnes : FillRandom;
    if (overflow) begin
      addr = sb.own_addr;
      fc = FcWriteRegs;
      count = $urandom_range(248, 255);
    end
    build_request(addr, fc, count, $urandom_range(0, 6) != 0, fill);
    if (!overflow && kind < 8) begin
      // cut short, the next frame start drops it
      count = $urandom_range(1, tx_bytes.size() - 1);
      while (tx_bytes.size() > count) void'(tx_bytes.pop_back());
    end else if (!overflow && kind < 16) begin
      tx_bytes.delete();
      repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) < 3);
    end
    // bytes after the end of a frame are skipped
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0);
  endfunction

  // one input transaction, with sender gaps between bursts
  task automatic send_byte(input in_t item);
    if (burst_left <= 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    in_valid_i = 1'b1;
    in_data_i = item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(sb.note_byte(item));
    sent_bytes++;
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_queued();
    foreach (tx_bytes[i]) send_byte(tx_bytes[i]);
    tx_bytes.delete();
  endtask

  // hold the sender until every owed result is out, then let the pipeline drain
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (sb.verdicts_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_address(input logic [7:0] a);
    cfg_valid_i = 1'b1;
    cfg_data_i = a;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.own_addr = a;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // receiver: switches among back-pressure patterns, holding each for a random span
  initial begin : result_sink
    sink_mode_e mode;
    int         span;
    int         cyc;
    out_ready_i = 1'b0;
    cyc = 0;
    forever begin
      mode = sink_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 100);
      repeat (span) begin
        @(negedge clk_i);
        cyc++;
        case (mode)
          SinkOpen:   out_ready_i = 1'b1;
          SinkCoin:   out_ready_i = 1'($urandom_range(0, 1));
          SinkSparse: out_ready_i = ($urandom_range(0, 4) == 0);
          default:    out_ready_i = ((cyc % 7) < 2);
        endcase
      end
    end
  end

  // every accepted result transaction is checked against the oldest verdict owed
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin : stimulus
    logic [7:0] addr_plan [5];
    int         target;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    burst_left = 0;
    sent_bytes = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: stray bytes before any frame start, all-ones and all-zero
    // bodies, an unsupported code, a short broadcast frame with bad crc,
    // an empty counted write and a frame cut short by a new frame start
    add_byte(8'h01, 1'b0);
    add_byte(8'h03, 1'b0);
    build_request(8'd1, FcReadHolding, 0, 1'b1, FillOnes);
    build_request(8'd1, FcReadDiscrete, 0, 1'b1, FillZero);
    while (tx_bytes.size() > 12) void'(tx_bytes.pop_back());
    add_byte(8'd1, 1'b1);
    add_byte(FcWriteReg, 1'b0);
    add_byte(8'hFF, 1'b0);
    build_request(8'd0, FcReadExcStatus, 0, 1'b0, FillZero);
    build_request(8'd1, FcWriteRegs, 0, 1'b1, FillZero);
    send_queued();

    // random phases, each under its own station address, extremes included
    addr_plan[0] = 8'd247;
    addr_plan[1] = 8'd0;
    addr_plan[2] = 8'd255;
    addr_plan[3] = 8'($urandom_range(2, 246));
    addr_plan[4] = 8'd1;
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_address(addr_plan[p]);
      target = sent_bytes + 270;
      if (p == 2 || p == 3) begin
        random_frame(1'b1);
        send_queued();
      end
      while (sent_bytes < target) begin
        // now and then let everything drain before going on
        if ($urandom_range(0, 39) == 0) wait_idle();
        random_frame(1'b0);
        send_queued();
      end
    end
    in_valid_i = 1'b0;

    while (sb.verdicts_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    sb.flag_missing();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
